// ===== design/signed_int_to_decimal_ascii_assert.svh =====
// assertion macros used by signed_int_to_decimal_ascii
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

`ifndef SYNTHESIS
`define SIDA_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define SIDA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define SIDA_ASSERT(label, cond)
`define SIDA_ASSERT_IMP(label, ante, cons)
`endif

`endif

// ===== design/sida_pkg.sv =====
package sida_pkg;

    localparam int IN_WIDTH    = 64;
    localparam int VALUE_WIDTH = 64;
    localparam int STEP_BITS   = 4;
    localparam int STEPS       = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int MAG_W       = STEPS * STEP_BITS;
    // digits of the largest magnitude, two to the power VALUE_WIDTH-1
    localparam int DIGITS      = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int BCD_W       = DIGITS * 4;
    localparam int STEP_W      = $clog2(STEPS);
    localparam int DCNT_W      = $clog2(DIGITS);

    typedef logic [5:0]           char_t;
    typedef logic [BCD_W-1:0]     bcd_t;
    typedef logic [STEP_BITS-1:0] bits_t;

    localparam char_t CHAR_ZERO  = 6'd48;
    localparam char_t CHAR_MINUS = 6'd45;

endpackage

// ===== design/signed_int_to_decimal_ascii.sv =====
// operation: after the input transfer, 16 conversion steps of four bits each, then the
// sign if negative and the digit slots, skipped leading zeros loading nothing into the
// output register; from the first digit, one character per cycle while not stalled
// input: in_stall holds off the next value until the last digit slot (transfer, 16
// shift-add-3 steps, the sign if negative, 19 digit slots incl. skipped zeros)
// reset: asynchronous active-low rst_n returns the sequencer to idle, no output pending
module signed_int_to_decimal_ascii (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [sida_pkg::IN_WIDTH-1:0] value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output sida_pkg::char_t               text_char,
    output logic                          last_char
);
    import sida_pkg::*;

    `include "signed_int_to_decimal_ascii_assert.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [MAG_W-1:0]       mag_reg, mag_next;
    bcd_t                   bcd_reg, bcd_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [DCNT_W-1:0]      dcnt_reg, dcnt_next;
    logic                   neg_reg, neg_next;
    logic                   started_reg, started_next;
    logic                   out_valid_reg, out_valid_next;
    char_t                  char_reg, char_next;
    logic                   last_reg, last_next;

    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag;
    bcd_t                   bcd_stepped;
    logic [3:0]             top_digit;
    logic                   out_free;
    logic                   in_xfer;

    sida_bcd_step u_step (
        .bcd         (bcd_reg),
        .bits        (mag_reg[MAG_W-1 -: STEP_BITS]),
        .bcd_shifted (bcd_stepped)
    );

    assign raw       = value[VALUE_WIDTH-1:0];
    // the most negative value negates to its own bit pattern, read as unsigned
    assign mag       = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        step_next      = step_reg;
        dcnt_next      = dcnt_reg;
        neg_next       = neg_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    mag_next   = MAG_W'(mag);
                    neg_next   = raw[VALUE_WIDTH-1];
                    bcd_next   = '0;
                    step_next  = STEP_W'(STEPS - 1);
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next = bcd_stepped;
                mag_next = mag_reg << STEP_BITS;
                if (step_reg == '0)
                begin
                    dcnt_next    = DCNT_W'(DIGITS - 1);
                    started_next = 1'b0;
                    state_next   = neg_reg ? ST_SIGN : ST_EMIT;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // leading zeros shift out without a transfer, the units digit always goes
                if (!started_reg && top_digit == 4'd0 && dcnt_reg != '0)
                begin
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                    dcnt_next = dcnt_reg - 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_ZERO + char_t'(top_digit);
                    last_next      = (dcnt_reg == '0);
                    started_next   = 1'b1;
                    bcd_next       = {bcd_reg[BCD_W-5:0], 4'd0};
                    if (dcnt_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        dcnt_next = dcnt_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            dcnt_reg      <= '0;
            started_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            dcnt_reg      <= dcnt_next;
            started_reg   <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign text_char = char_reg;
    assign last_char = last_reg;

    `SIDA_ASSERT_IMP(a_char_range, out_valid_reg,
        char_reg == CHAR_MINUS || (char_reg >= CHAR_ZERO && char_reg <= CHAR_ZERO + 6'd9))
    `SIDA_ASSERT_IMP(a_minus_not_last, out_valid_reg && char_reg == CHAR_MINUS, !last_reg)
    `SIDA_ASSERT_IMP(a_no_input_mid_text, in_xfer, !out_valid_reg || last_reg)
    `SIDA_ASSERT_IMP(a_conv_no_output, state_reg == ST_CONV && $past(state_reg == ST_CONV),
        !out_valid_reg || last_reg)

endmodule

// ===== design/sida_bcd_step.sv =====
module sida_bcd_step (
    input  sida_pkg::bcd_t  bcd,
    input  sida_pkg::bits_t bits,
    output sida_pkg::bcd_t  bcd_shifted
);
    import sida_pkg::*;

    bcd_t work;

    // shift-add-3 over STEP_BITS input bits, msb first
    always_comb
    begin
        work = bcd;
        for (int s = 0; s < STEP_BITS; s++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                if (work[d*4 +: 4] >= 4'd5)
                begin
                    work[d*4 +: 4] = work[d*4 +: 4] + 4'd3;
                end
            end
            work = {work[BCD_W-2:0], bits[STEP_BITS-1-s]};
        end
        bcd_shifted = work;
    end

endmodule
